>>> hdl/pcfe_pkg.sv
// Shared types, constants and codes for the palette channel fade engine.
package pcfe_pkg;

   localparam int ENTRIES = 64;
   localparam int POS_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int IDX_W   = 6;
   localparam int CMP_W   = 9;
   localparam int CH_W    = 8;
   localparam int NUM_CH  = 3;

   localparam logic [CH_W-1:0] TOP_LEVEL   = 8'd224;
   localparam logic [CH_W-1:0] FADE_STEP   = 8'd32;
   localparam logic [3:0]      PHASE_TICKS = 4'd8;
   localparam logic [1:0]      PHASES      = 2'd3;

   localparam logic [2:0] OP_WRITE    = 3'd0;
   localparam logic [2:0] OP_READ     = 3'd1;
   localparam logic [2:0] OP_FADE_IN  = 3'd2;
   localparam logic [2:0] OP_FADE_OUT = 3'd3;
   localparam logic [2:0] OP_TICK     = 3'd4;

   localparam logic [1:0] MODE_IDLE     = 2'd0;
   localparam logic [1:0] MODE_FADE_IN  = 2'd1;
   localparam logic [1:0] MODE_FADE_OUT = 2'd2;

   // element 0 red, 1 green, 2 blue
   typedef logic [NUM_CH-1:0][CH_W-1:0] rgb_type;

   typedef struct packed {
      rgb_type cur;
      rgb_type sav;
   } entry_type;

   typedef enum logic [2:0] {
      SWEEP_WRITE,
      SWEEP_READ,
      SWEEP_SAVE,
      SWEEP_FADE_IN,
      SWEEP_FADE_OUT
   } sweep_kind_type;

   typedef struct packed {
      sweep_kind_type    kind;
      logic [1:0]        channel;
      logic [CH_W-1:0]   mask;
      logic [IDX_W-1:0]  index;
      rgb_type           wdata;
   } sweep_cmd_type;

   typedef struct packed {
      logic    hit;
      rgb_type data;
   } read_tap_type;

   typedef enum logic {
      ST_IDLE,
      ST_SWEEP
   } state_type;

endpackage

>>> hdl/pcfe_if.sv
// Request and response channel interfaces of the palette channel fade engine.
interface pcfe_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] op;
   logic [5:0] entry_index;
   logic [7:0] red_in;
   logic [7:0] green_in;
   logic [7:0] blue_in;

   modport source (output valid, op, entry_index, red_in, green_in, blue_in, input ready);
   modport sink (input valid, op, entry_index, red_in, green_in, blue_in, output ready);
endinterface

interface pcfe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_out;
   logic [7:0] green_out;
   logic [7:0] blue_out;
   logic [1:0] fade_mode;

   modport source (output valid, red_out, green_out, blue_out, fade_mode, input ready);
   modport sink (input valid, red_out, green_out, blue_out, fade_mode, output ready);
endinterface

>>> hdl/pcfe_cell.sv
// One palette cell: holds an entry and its saved copy, shifts them on.
module pcfe_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               shift,
   input  pcfe_pkg::entry_type d,
   output pcfe_pkg::entry_type q
);
   import pcfe_pkg::*;

   rgb_type cur_ff;
   rgb_type sav_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff <= '0;
      end else if (shift) begin
         cur_ff <= d.cur;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         sav_ff <= d.sav;
      end
   end

   assign q.cur = cur_ff;
   assign q.sav = sav_ff;

endmodule

>>> hdl/pcfe_update.sv
// Head-of-ring update: applies the running sweep to the entry passing by.
module pcfe_update (
   input  pcfe_pkg::sweep_cmd_type      cmd,
   input  logic [pcfe_pkg::POS_W-1:0]   step,
   input  pcfe_pkg::entry_type          d,
   output pcfe_pkg::entry_type          q,
   output pcfe_pkg::read_tap_type       tap
);
   import pcfe_pkg::*;

   logic hit;

   assign hit = (CMP_W'(cmd.index) == CMP_W'(step));

   always_comb begin
      q        = d;
      tap.hit  = 1'b0;
      tap.data = d.cur;
      unique case (cmd.kind)
         SWEEP_WRITE: begin
            if (hit) begin
               q.cur = cmd.wdata;
            end
         end
         SWEEP_READ: begin
            tap.hit = hit;
         end
         SWEEP_SAVE: begin
            q.sav = d.cur;
            q.cur = {NUM_CH{TOP_LEVEL}};
         end
         SWEEP_FADE_IN: begin
            for (int c = 0; c < NUM_CH; c++) begin
               if (2'(c) == cmd.channel) begin
                  q.cur[c] = (d.sav[c] < cmd.mask) ? cmd.mask : d.sav[c];
               end
            end
         end
         SWEEP_FADE_OUT: begin
            for (int c = 0; c < NUM_CH; c++) begin
               if (2'(c) == cmd.channel && d.cur[c] < TOP_LEVEL) begin
                  q.cur[c] = d.cur[c] + FADE_STEP;
               end
            end
         end
         default: begin
            q = d;
         end
      endcase
   end

endmodule

>>> hdl/palette_channel_fade_engine_top.sv
// Palette channel fade engine: a ring of palette cells swept through one update stage.
// Writes, reads, fade-in start and fading ticks rotate the whole ring once through the one
// update stage at the ring head; the response is registered after the last step of the sweep.
// Fade-out start, idle, phase-step and fade-end ticks and unused codes respond next cycle.
// One request at a time; the next is taken once the ring is at rest and the response slot frees.
// Sync reset: palette, phase cleared; mode idle; tick count, mask preset; saved copy unset.
module palette_channel_fade_engine_top (
   input  logic clock,
   input  logic reset,
   pcfe_req_if.sink   req_chan,
   pcfe_rsp_if.source rsp_chan
);
   import pcfe_pkg::*;

   state_type       state_ff, state_in;
   logic [POS_W-1:0] step_ff, step_in;
   sweep_cmd_type   cmd_ff, cmd_in;
   logic [1:0]      mode_ff, mode_in;
   logic [1:0]      phase_ff, phase_in;
   logic [3:0]      tick_ff, tick_in;
   logic [CH_W-1:0] mask_ff, mask_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rgb_type         rsp_rgb_ff, rsp_rgb_in;

   logic            accept;
   logic            need_sweep;
   logic            shift;
   logic            last_step;
   logic            ready;

   entry_type       ring [ENTRIES];
   entry_type       head_out;
   read_tap_type    tap;

   // ring of cells, cell k takes from cell k+1, the last takes the updated head
   for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
      entry_type d_k;
      if (k == ENTRIES - 1) begin : g_last
         assign d_k = head_out;
      end else begin : g_mid
         assign d_k = ring[k+1];
      end
      pcfe_cell u_cell (
         .clock (clock),
         .reset (reset),
         .shift (shift),
         .d     (d_k),
         .q     (ring[k])
      );
   end

   pcfe_update u_update (
      .cmd  (cmd_ff),
      .step (step_ff),
      .d    (ring[0]),
      .q    (head_out),
      .tap  (tap)
   );

   assign last_step = (step_ff == POS_W'(ENTRIES - 1));
   assign accept    = req_chan.valid && ready;

   // request decode and fade state
   always_comb begin
      mode_in        = mode_ff;
      phase_in       = phase_ff;
      tick_in        = tick_ff;
      mask_in        = mask_ff;
      cmd_in         = cmd_ff;
      need_sweep     = 1'b0;
      cmd_in.index   = req_chan.entry_index;
      cmd_in.wdata   = {req_chan.blue_in, req_chan.green_in, req_chan.red_in};
      cmd_in.channel = phase_ff;
      cmd_in.mask    = mask_ff;
      unique case (req_chan.op)
         OP_WRITE: begin
            need_sweep  = 1'b1;
            cmd_in.kind = SWEEP_WRITE;
         end
         OP_READ: begin
            need_sweep  = 1'b1;
            cmd_in.kind = SWEEP_READ;
         end
         OP_FADE_IN: begin
            need_sweep  = 1'b1;
            cmd_in.kind = SWEEP_SAVE;
            mode_in     = MODE_FADE_IN;
            tick_in     = PHASE_TICKS;
            phase_in    = 2'd0;
            mask_in     = TOP_LEVEL;
         end
         OP_FADE_OUT: begin
            mode_in  = MODE_FADE_OUT;
            tick_in  = PHASE_TICKS;
            phase_in = 2'd0;
         end
         OP_TICK: begin
            if (mode_ff == MODE_FADE_IN || mode_ff == MODE_FADE_OUT) begin
               priority if (phase_ff >= PHASES) begin
                  mode_in = MODE_IDLE;
               end else if (tick_ff != 4'd0) begin
                  tick_in    = tick_ff - 4'd1;
                  need_sweep = 1'b1;
                  if (mode_ff == MODE_FADE_IN) begin
                     cmd_in.kind = SWEEP_FADE_IN;
                     mask_in     = mask_ff - FADE_STEP;
                  end else begin
                     cmd_in.kind = SWEEP_FADE_OUT;
                  end
               end else begin
                  tick_in  = PHASE_TICKS;
                  phase_in = phase_ff + 2'd1;
                  if (mode_ff == MODE_FADE_IN) begin
                     mask_in = TOP_LEVEL;
                  end
               end
            end
         end
         default: begin
            need_sweep = 1'b0;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && need_sweep) begin
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (last_step) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      ready = 1'b0;
      shift = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            ready = !rsp_valid_ff || rsp_chan.ready;
         end
         ST_SWEEP: begin
            shift = 1'b1;
         end
         default: begin
            ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      step_in = step_ff;
      if (shift) begin
         step_in = last_step ? '0 : step_ff + POS_W'(1);
      end
   end

   always_comb begin
      rsp_rgb_in = rsp_rgb_ff;
      if (accept) begin
         rsp_rgb_in = '0;
      end else if (shift && tap.hit) begin
         rsp_rgb_in = tap.data;
      end
   end

   always_comb begin
      priority if (accept && !need_sweep) begin
         rsp_valid_in = 1'b1;
      end else if (shift && last_step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         mode_ff      <= MODE_IDLE;
         phase_ff     <= 2'd0;
         tick_ff      <= PHASE_TICKS;
         mask_ff      <= TOP_LEVEL;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            mode_ff  <= mode_in;
            phase_ff <= phase_in;
            tick_ff  <= tick_in;
            mask_ff  <= mask_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_rgb_ff <= rsp_rgb_in;
      if (accept) begin
         cmd_ff <= cmd_in;
      end
   end

   assign req_chan.ready     = ready;
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.red_out   = rsp_rgb_ff[0];
   assign rsp_chan.green_out = rsp_rgb_ff[1];
   assign rsp_chan.blue_out  = rsp_rgb_ff[2];
   assign rsp_chan.fade_mode = mode_ff;

endmodule
